FILE: rtl/aesctr_pkg.sv
package aesctr_pkg;

	localparam int unsigned NumRounds = 14;
	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned CfgDataW  = 64;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] REG_KEY0   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY1   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY2   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_KEY3   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_IV_HI  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_IV_LO  = 3'd5;

	// control from the byte side to the keystream engine
	typedef struct packed {
		logic         restart;
		logic [255:0] key;
		logic [127:0] iv;
	} ctl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	localparam logic [7:0] RCON [8] = '{
		8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
	};

	// byte k of a block, byte 0 in the top bits
	function automatic logic [7:0] blk_byte(input logic [127:0] b, input logic [3:0] k);
		return b[8'd127 - {1'b0, k, 3'b000} -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// byte substitution with row shift
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(r + 4*c) -: 8] = SBOX[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, al;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32*c -: 8];
			a1 = s[119 - 32*c -: 8];
			a2 = s[111 - 32*c -: 8];
			a3 = s[103 - 32*c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			t[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			t[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			t[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

	// round key i from round keys i-2 and i-1
	function automatic logic [127:0] next_rkey(input logic [127:0] k2, input logic [127:0] k1,
			input logic [3:0] i);
		logic [31:0] tmp, w0, w1, w2, w3;
		if (!i[0])
			tmp = sub_word({k1[23:0], k1[31:24]}) ^ {RCON[i[3:1]], 24'h0};
		else
			tmp = sub_word(k1[31:0]);
		w0 = k2[127:96] ^ tmp;
		w1 = k2[95:64] ^ w0;
		w2 = k2[63:32] ^ w1;
		w3 = k2[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

FILE: rtl/aesctr_queue.sv
module aesctr_queue
	import aesctr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tuser,   // [0] message_start
	output logic       head_vld,
	output logic [7:0] head_data,
	output logic       head_ms,
	input  logic       head_pop
);

	logic [8:0] slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign s_axis_tready = (cnt_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign head_vld      = (cnt_q != 2'd0);
	assign head_data     = slot_q[rd_ptr_q][7:0];
	assign head_ms       = slot_q[rd_ptr_q][8];

	// store incoming words
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= {s_axis_tuser, s_axis_tdata};
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (head_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, head_pop};
		end
	end

endmodule

FILE: rtl/aesctr_engine.sv
module aesctr_engine
	import aesctr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  ctl_t         ctl,
	output logic         blk_vld,
	output logic [127:0] blk,
	input  logic         blk_take
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_KEXP = 2'd1;
	localparam logic [1:0] ST_ENC  = 2'd2;

	logic [1:0]   state_q;
	logic [3:0]   rnd_q;
	logic [127:0] rk_mem [NumRounds + 1];
	logic [127:0] kp2_q, kp1_q, st_q, ctr_q, blk_q;
	logic         blk_vld_q;
	logic [3:0]   rd_idx;
	logic [127:0] rk_rd, rk_new, rnd_sub, rnd_out;
	logic         last_rnd;

	assign rd_idx   = (state_q == ST_ENC) ? rnd_q : 4'd0;
	assign rk_rd    = rk_mem[rd_idx];
	assign rk_new   = next_rkey(kp2_q, kp1_q, rnd_q);
	assign last_rnd = (rnd_q == 4'(NumRounds));
	assign rnd_sub  = sub_shift(st_q);
	assign rnd_out  = (last_rnd ? rnd_sub : mix_columns(rnd_sub)) ^ rk_rd;
	assign blk_vld  = blk_vld_q;
	assign blk      = blk_q;

	// round key store and datapath registers
	always_ff @(posedge clk) begin
		if (ctl.restart) begin
			rk_mem[0] <= ctl.key[255:128];
			rk_mem[1] <= ctl.key[127:0];
			kp2_q     <= ctl.key[255:128];
			kp1_q     <= ctl.key[127:0];
		end else if (state_q == ST_KEXP) begin
			rk_mem[rnd_q] <= rk_new;
			kp2_q         <= kp1_q;
			kp1_q         <= rk_new;
		end
		if (state_q == ST_IDLE) begin
			st_q <= ctr_q ^ rk_rd;
		end else if (state_q == ST_ENC) begin
			st_q <= rnd_out;
		end
		if (state_q == ST_ENC && last_rnd && !ctl.restart) begin
			blk_q <= rnd_out;
		end
	end

	// sequence key expansion and rounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rnd_q     <= 4'd0;
			ctr_q     <= '0;
			blk_vld_q <= 1'b0;
		end else if (ctl.restart) begin
			state_q   <= ST_KEXP;
			rnd_q     <= 4'd2;
			ctr_q     <= ctl.iv;
			blk_vld_q <= 1'b0;
		end else begin
			if (blk_take) blk_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!blk_vld_q) begin
						state_q <= ST_ENC;
						rnd_q   <= 4'd1;
					end
				end
				ST_KEXP: begin
					if (last_rnd) state_q <= ST_IDLE;
					else rnd_q <= rnd_q + 4'd1;
				end
				ST_ENC: begin
					if (last_rnd) begin
						state_q   <= ST_IDLE;
						blk_vld_q <= 1'b1;
						ctr_q     <= ctr_q + 128'd1;
					end else begin
						rnd_q <= rnd_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/aes256_ctr_stream_cipher.sv
// AES-256 counter-mode byte cipher. Program key_bits_0..3 and iv_high/iv_low
// over the write port, then send bytes on s_axis with tuser set on the first
// byte of each message; each byte comes back on m_axis XORed with the next
// keystream byte. The engine runs one AES round per cycle and computes the
// next 16-byte block while the current one is used, so the stream runs at
// one byte per cycle while m_axis_tready is high. A message start stalls the
// input while key and counter are loaded, the 13 remaining round keys are
// expanded (one round key per cycle) and the first block is computed.
module aes256_ctr_stream_cipher
	import aesctr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,  // [7:0] data_byte
	input  logic                s_axis_tuser,  // [0] message_start
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata   // [7:0] out_byte
);

	logic [63:0]  key0_q, key1_q, key2_q, key3_q, ivh_q, ivl_q;
	logic         head_vld, head_ms, head_pop;
	logic [7:0]   head_data;
	ctl_t         ctl;
	logic         blk_vld, blk_take;
	logic [127:0] blk, ks_cur_q;
	logic [4:0]   pos_q;
	logic         rst_done_q, out_vld_q, can_out, ks_ready;
	logic [7:0]   out_q, ks_byte;

	aesctr_queue u_queue (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.head_vld, .head_data, .head_ms, .head_pop
	);

	aesctr_engine u_engine (
		.clk, .arst_n, .ctl, .blk_vld, .blk, .blk_take
	);

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0;
			ivh_q  <= '0; ivl_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_KEY0:  key0_q <= cfg_data;
				REG_KEY1:  key1_q <= cfg_data;
				REG_KEY2:  key2_q <= cfg_data;
				REG_KEY3:  key3_q <= cfg_data;
				REG_IV_HI: ivh_q  <= cfg_data;
				REG_IV_LO: ivl_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// restart the engine once per message-start word
	assign ctl.restart = head_vld && head_ms && !rst_done_q;
	assign ctl.key     = {key0_q, key1_q, key2_q, key3_q};
	assign ctl.iv      = {ivh_q, ivl_q};

	assign can_out  = !out_vld_q || m_axis_tready;
	assign ks_ready = !pos_q[4] || blk_vld;
	assign head_pop = head_vld && can_out && !ctl.restart && ks_ready;
	assign blk_take = head_pop && pos_q[4];
	assign ks_byte  = pos_q[4] ? blk_byte(blk, 4'd0) : blk_byte(ks_cur_q, pos_q[3:0]);

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	// output word and keystream buffer
	always_ff @(posedge clk) begin
		if (head_pop) out_q <= head_data ^ ks_byte;
		if (blk_take) ks_cur_q <= blk;
	end

	// track byte position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= 5'd16;
			rst_done_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (ctl.restart) begin
				pos_q      <= 5'd16;
				rst_done_q <= 1'b1;
			end else if (head_pop) begin
				pos_q      <= pos_q[4] ? 5'd1 : pos_q + 5'd1;
				rst_done_q <= 1'b0;
			end
			if (head_pop) out_vld_q <= 1'b1;
			else if (m_axis_tready) out_vld_q <= 1'b0;
		end
	end

endmodule
